// File: sv/gstp_pkg.sv
// ----------------------------------------------------------------------------
// gstp_pkg
// Shared constants, types and helpers for the gnomonic sky-to-pixel pipeline.
// ----------------------------------------------------------------------------
package gstp_pkg;

  // Angle units: 2^-20 degree
  localparam int DEG_UNIT     = 1048576;
  localparam int HALF_TURN    = 180 * DEG_UNIT;
  localparam int QUARTER_TURN = 90 * DEG_UNIT;
  localparam int FULL_TURN    = 360 * DEG_UNIT;

  // CORDIC
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int XW           = 33;   // Q2.30 datapath width
  localparam int ZW           = 29;   // residual angle width
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  // Divider and overall latency
  localparam int DIV_BITS    = 64;
  localparam int OUT_LATENCY = 1 + CORDIC_LAT + 4 + DIV_BITS + 6;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_REF_RA    = 3'd0,
    REG_REF_DEC   = 3'd1,
    REG_INV_CD_XX = 3'd2,
    REG_INV_CD_YX = 3'd3,
    REG_INV_CD_XY = 3'd4,
    REG_INV_CD_YY = 3'd5,
    REG_REF_PIX_X = 3'd6,
    REG_REF_PIX_Y = 3'd7
  } reg_idx_t;

  // Q30 x Q30 product rounded to Q30
  function automatic logic signed [XW-1:0] mul30(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
    logic signed [2*XW-1:0] p;
    p = a * b + (2*XW)'(536870912);
    return p[XW+29:30];
  endfunction

endpackage

// File: sv/gnomonic_sky_to_pixel.sv
// ----------------------------------------------------------------------------
// gnomonic_sky_to_pixel
// Gnomonic tangent-plane projection of (RA, Dec) to saturated Q16.16 pixels.
// ----------------------------------------------------------------------------
//  channel   signals                                     direction
//  -------   ------------------------------------------  ---------
//  command   start, right_ascension, declination,        in
//            zero_based (busy is an output)
//  result    done, pixel_x, pixel_y, out_of_range        out
//  config    cfg_we, cfg_index, cfg_data                 in
//
// One transaction enters per cycle; busy stays low. Each result passes
// through the 24-step CORDIC and the 64-stage bit-per-cycle divider. rst
// clears the valid pipeline and the configuration registers; results are
// shown with done for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module gnomonic_sky_to_pixel (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [28:0]        right_ascension,
  input  logic signed [27:0] declination,
  input  logic               zero_based,
  output logic               done,
  output logic signed [31:0] pixel_x,
  output logic signed [31:0] pixel_y,
  output logic               out_of_range,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [39:0]        cfg_data
);
  import gstp_pkg::*;

  // Configuration registers
  logic [28:0]        ref_ra;
  logic signed [27:0] ref_dec;
  logic signed [39:0] inv_cd [4];   // xx, yx, xy, yy
  logic signed [31:0] ref_pix_x;
  logic signed [31:0] ref_pix_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_ra    <= '0;
      ref_dec   <= '0;
      for (int k = 0; k < 4; k++) inv_cd[k] <= '0;
      ref_pix_x <= '0;
      ref_pix_y <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_REF_RA:    ref_ra    <= cfg_data[28:0];
        REG_REF_DEC:   ref_dec   <= cfg_data[27:0];
        REG_INV_CD_XX: inv_cd[0] <= cfg_data;
        REG_INV_CD_YX: inv_cd[1] <= cfg_data;
        REG_INV_CD_XY: inv_cd[2] <= cfg_data;
        REG_INV_CD_YY: inv_cd[3] <= cfg_data;
        REG_REF_PIX_X: ref_pix_x <= cfg_data[31:0];
        REG_REF_PIX_Y: ref_pix_y <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data
  logic accept;
  logic [OUT_LATENCY:1] vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_LATENCY-1:1], accept};
    end
  end

  // Stage A: reduce the three angles into [0, 360) deg
  logic signed [31:0] d_ra;
  logic [28:0]        u_ra, u_dec, u_dec0;
  logic [28:0]        a_ra, a_dec, a_dec0;
  logic               zb_a;

  always_comb begin
    d_ra = 32'(signed'({1'b0, right_ascension})) - 32'(signed'({1'b0, ref_ra}));
    if (d_ra >= FULL_TURN)       u_ra = 29'(d_ra - FULL_TURN);
    else if (d_ra >= 0)          u_ra = 29'(d_ra);
    else if (d_ra >= -FULL_TURN) u_ra = 29'(d_ra + FULL_TURN);
    else                         u_ra = 29'(d_ra + 2 * FULL_TURN);
    u_dec  = (declination < 0) ? 29'(declination + FULL_TURN) : 29'(declination);
    u_dec0 = (ref_dec < 0) ? 29'(ref_dec + FULL_TURN) : 29'(ref_dec);
  end

  always_ff @(posedge clk) begin
    a_ra   <= u_ra;
    a_dec  <= u_dec;
    a_dec0 <= u_dec0;
    zb_a   <= zero_based;
  end

  // Sine and cosine units
  logic signed [XW-1:0] sd, cd, sd0, cd0, sda, cda;

  gstp_cordic u_cordic_dec  (.clk(clk), .angle(a_dec),  .sin_q(sd),  .cos_q(cd));
  gstp_cordic u_cordic_dec0 (.clk(clk), .angle(a_dec0), .sin_q(sd0), .cos_q(cd0));
  gstp_cordic u_cordic_ra   (.clk(clk), .angle(a_ra),   .sin_q(sda), .cos_q(cda));

  // zero_based follows the CORDIC latency
  logic zb_c [0:CORDIC_LAT-1];

  always_ff @(posedge clk) begin
    zb_c[0] <= zb_a;
    for (int i = 0; i < CORDIC_LAT - 1; i++) zb_c[i+1] <= zb_c[i];
  end

  // M1..M4: numerators, denominator, dividend setup
  logic signed [XW-1:0] m1_cdc, m1_xnum, m1_p1, m1_sd0, m1_cd0, m1_sd;
  logic signed [XW-1:0] m2_q1, m2_q2, m2_q3, m2_xnum, m2_p1;
  logic signed [XW:0]   m3_den, m3_ynum, m3_xnum;
  logic                 m1_zb, m2_zb, m3_zb;
  logic [XW:0]          ux, uy;

  always_comb begin
    ux = (m3_xnum < 0) ? (XW+1)'(-m3_xnum) : (XW+1)'(m3_xnum);
    uy = (m3_ynum < 0) ? (XW+1)'(-m3_ynum) : (XW+1)'(m3_ynum);
  end

  // Divider stage arrays (index 0 is the setup register)
  logic [DIV_BITS-1:0] dn_x [0:DIV_BITS];
  logic [DIV_BITS-1:0] dn_y [0:DIV_BITS];
  logic [DIV_BITS-1:0] dq_x [0:DIV_BITS];
  logic [DIV_BITS-1:0] dq_y [0:DIV_BITS];
  logic [XW-1:0]       dr_x [0:DIV_BITS];
  logic [XW-1:0]       dr_y [0:DIV_BITS];
  logic [XW-1:0]       dd   [0:DIV_BITS];
  logic                dnx  [0:DIV_BITS];
  logic                dny  [0:DIV_BITS];
  logic                dfar [0:DIV_BITS];
  logic                dzb  [0:DIV_BITS];

  always_ff @(posedge clk) begin
    m1_cdc  <= mul30(cd, cda);
    m1_xnum <= mul30(cd, sda);
    m1_p1   <= mul30(sd0, sd);
    m1_sd0  <= sd0;
    m1_cd0  <= cd0;
    m1_sd   <= sd;
    m1_zb   <= zb_c[CORDIC_LAT-1];

    m2_q1   <= mul30(m1_cd0, m1_cdc);
    m2_q2   <= mul30(m1_cd0, m1_sd);
    m2_q3   <= mul30(m1_sd0, m1_cdc);
    m2_xnum <= m1_xnum;
    m2_p1   <= m1_p1;
    m2_zb   <= m1_zb;

    m3_den  <= (XW+1)'(m2_p1) + (XW+1)'(m2_q1);
    m3_ynum <= (XW+1)'(m2_q2) - (XW+1)'(m2_q3);
    m3_xnum <= (XW+1)'(m2_xnum);
    m3_zb   <= m2_zb;

    // Dividend is |num| * 2^30 plus half the divisor for rounding
    dn_x[0] <= (DIV_BITS'(ux) << 30) + DIV_BITS'(m3_den[XW:1]);
    dn_y[0] <= (DIV_BITS'(uy) << 30) + DIV_BITS'(m3_den[XW:1]);
    dq_x[0] <= '0;
    dq_y[0] <= '0;
    dr_x[0] <= '0;
    dr_y[0] <= '0;
    dd[0]   <= m3_den[XW-1:0];
    dnx[0]  <= m3_xnum < 0;
    dny[0]  <= m3_ynum < 0;
    dfar[0] <= m3_den <= 0;
    dzb[0]  <= m3_zb;
  end

  // Restoring divider: one quotient bit per stage
  logic [XW:0] r2x [DIV_BITS];
  logic [XW:0] r2y [DIV_BITS];
  logic        gex [DIV_BITS];
  logic        gey [DIV_BITS];

  always_comb begin
    for (int i = 0; i < DIV_BITS; i++) begin
      r2x[i] = {dr_x[i], dn_x[i][DIV_BITS-1]};
      r2y[i] = {dr_y[i], dn_y[i][DIV_BITS-1]};
      gex[i] = r2x[i] >= {1'b0, dd[i]};
      gey[i] = r2y[i] >= {1'b0, dd[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_BITS; i++) begin
      dr_x[i+1] <= gex[i] ? XW'(r2x[i] - {1'b0, dd[i]}) : XW'(r2x[i]);
      dr_y[i+1] <= gey[i] ? XW'(r2y[i] - {1'b0, dd[i]}) : XW'(r2y[i]);
      dn_x[i+1] <= dn_x[i] << 1;
      dn_y[i+1] <= dn_y[i] << 1;
      dq_x[i+1] <= {dq_x[i][DIV_BITS-2:0], gex[i]};
      dq_y[i+1] <= {dq_y[i][DIV_BITS-2:0], gey[i]};
      dd[i+1]   <= dd[i];
      dnx[i+1]  <= dnx[i];
      dny[i+1]  <= dny[i];
      dfar[i+1] <= dfar[i];
      dzb[i+1]  <= dzb[i];
    end
  end

  // T1..T4: matrix terms, |a| * |xi| split into 32-bit partial products
  logic [DIV_BITS-1:0] xm [4];
  logic                xn [4];
  logic [39:0]         ua [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xm[k] = (k % 2 == 0) ? dq_x[DIV_BITS] : dq_y[DIV_BITS];
      xn[k] = ((k % 2 == 0) ? dnx[DIV_BITS] : dny[DIV_BITS]) && (|xm[k]);
      ua[k] = (inv_cd[k] < 0) ? 40'(-inv_cd[k]) : 40'(inv_cd[k]);
    end
  end

  logic [63:0]         pp00 [4];
  logic [63:0]         pp01 [4];
  logic [39:0]         pp10 [4];
  logic [39:0]         pp11 [4];
  logic                t1_neg [4];
  logic [63:0]         t2_pp00 [4];
  logic [64:0]         t2_mid  [4];
  logic [39:0]         t2_pp11 [4];
  logic                t2_neg  [4];
  logic [103:0]        t3_p    [4];
  logic                t3_neg  [4];
  logic signed [41:0]  t4_term [4];
  logic                t_far [1:4];
  logic                t_zb  [1:4];

  logic [103:0]        rnd [4];
  logic [40:0]         mag [4];
  logic signed [41:0]  mag_s [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k]   = t3_p[k] + 104'(536870912);
      mag[k]   = (|rnd[k][103:70]) ? 41'(1) << 40 : 41'(rnd[k][69:30]);
      mag_s[k] = signed'(42'(mag[k]));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pp00[k]    <= 64'(ua[k][31:0]) * 64'(xm[k][31:0]);
      pp01[k]    <= 64'(ua[k][31:0]) * 64'(xm[k][63:32]);
      pp10[k]    <= 40'(ua[k][39:32]) * 40'(xm[k][31:0]);
      pp11[k]    <= 40'(ua[k][39:32]) * 40'(xm[k][63:32]);
      t1_neg[k]  <= (inv_cd[k] < 0) != xn[k];

      t2_pp00[k] <= pp00[k];
      t2_mid[k]  <= 65'(pp01[k]) + 65'(pp10[k]);
      t2_pp11[k] <= pp11[k];
      t2_neg[k]  <= t1_neg[k];

      t3_p[k]    <= 104'(t2_pp00[k]) + (104'(t2_mid[k]) << 32) + (104'(t2_pp11[k]) << 64);
      t3_neg[k]  <= t2_neg[k];

      t4_term[k] <= t3_neg[k] ? -mag_s[k] : mag_s[k];
    end
    t_far[1] <= dfar[DIV_BITS];
    t_zb[1]  <= dzb[DIV_BITS];
    for (int i = 1; i < 4; i++) begin
      t_far[i+1] <= t_far[i];
      t_zb[i+1]  <= t_zb[i];
    end
  end

  // T5: sum terms, reference pixel and zero-based offset
  logic signed [43:0] sum_x, sum_y;
  logic               s_far;

  always_ff @(posedge clk) begin
    sum_x <= 44'(t4_term[0]) + 44'(t4_term[1]) + 44'(ref_pix_x)
             - (t_zb[4] ? 44'sd65536 : 44'sd0);
    sum_y <= 44'(t4_term[2]) + 44'(t4_term[3]) + 44'(ref_pix_y)
             - (t_zb[4] ? 44'sd65536 : 44'sd0);
    s_far <= t_far[4];
  end

  // T6: saturate and register the result
  logic signed [31:0] sat_x, sat_y;
  logic               ovf_x, ovf_y;

  always_comb begin
    ovf_x = 1'b1;
    ovf_y = 1'b1;
    if (sum_x > 44'sd2147483647)       sat_x = 32'sh7FFFFFFF;
    else if (sum_x < -44'sd2147483648) sat_x = 32'sh80000000;
    else begin
      sat_x = 32'(sum_x);
      ovf_x = 1'b0;
    end
    if (sum_y > 44'sd2147483647)       sat_y = 32'sh7FFFFFFF;
    else if (sum_y < -44'sd2147483648) sat_y = 32'sh80000000;
    else begin
      sat_y = 32'(sum_y);
      ovf_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_far) begin
      pixel_x      <= '0;
      pixel_y      <= '0;
      out_of_range <= 1'b1;
    end else begin
      pixel_x      <= sat_x;
      pixel_y      <= sat_y;
      out_of_range <= ovf_x || ovf_y;
    end
  end

  assign done = vld[OUT_LATENCY];

endmodule

// File: sv/gstp_cordic.sv
// ----------------------------------------------------------------------------
// gstp_cordic
// Pipelined rotation-mode CORDIC: sine and cosine of an angle in [0, 360) deg.
// ----------------------------------------------------------------------------
module gstp_cordic (
  input  logic                         clk,
  input  logic [28:0]                  angle,
  output logic signed [gstp_pkg::XW-1:0] sin_q,
  output logic signed [gstp_pkg::XW-1:0] cos_q
);
  import gstp_pkg::*;

  logic signed [XW-1:0] x    [0:CORDIC_STEPS];
  logic signed [XW-1:0] y    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z    [0:CORDIC_STEPS];
  logic                 flip [0:CORDIC_STEPS];

  logic signed [31:0]   a_s;
  logic signed [ZW-1:0] z_fold;
  logic                 f_fold;

  // Fold into [-90, 90] deg; the half-turn moves negate both outputs
  always_comb begin
    a_s = signed'({3'b000, angle});
    if (a_s <= QUARTER_TURN) begin
      z_fold = ZW'(a_s);
      f_fold = 1'b0;
    end else if (a_s < 3 * QUARTER_TURN) begin
      z_fold = ZW'(a_s - HALF_TURN);
      f_fold = 1'b1;
    end else begin
      z_fold = ZW'(a_s - FULL_TURN);
      f_fold = 1'b0;
    end
  end

  // One micro-rotation per stage
  always_ff @(posedge clk) begin
    x[0]    <= XW'(CORDIC_GAIN);
    y[0]    <= '0;
    z[0]    <= z_fold;
    flip[0] <= f_fold;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ZW'(ATAN_TAB[i]);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ZW'(ATAN_TAB[i]);
      end
      flip[i+1] <= flip[i];
    end
    sin_q <= flip[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
    cos_q <= flip[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
  end

endmodule

// File: sv/gstp_checker.sv
// ----------------------------------------------------------------------------
// gstp_checker
// Port-level checks of the sky-to-pixel pipeline timing and result integrity.
// ----------------------------------------------------------------------------
module gstp_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] pixel_x,
  input logic signed [31:0] pixel_y,
  input logic               out_of_range
);
  import gstp_pkg::*;

  // Every transaction produces a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##OUT_LATENCY done)
    else $error("result missing after accepted transaction");

  // No result without a matching transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, OUT_LATENCY))
    else $error("result without a transaction");

  // Result fields are fully known whenever a result is shown
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({pixel_x, pixel_y, out_of_range}))
    else $error("unknown result fields");

endmodule

bind gnomonic_sky_to_pixel gstp_checker u_gstp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .pixel_x(pixel_x), .pixel_y(pixel_y), .out_of_range(out_of_range)
);
